// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the row step block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("row step assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("row step reset check failed");

`endif

// ===== design/llrs_pkg.sv =====
// Package for the life-like automaton row step: widths, reset values and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package llrs_pkg;

  localparam int ROW_W       = 64;
  localparam int MAX_WIDTH_D = 64;
  localparam int WIDTH_W     = 7;
  localparam int MASK_W      = 9;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int QDEPTH      = 3;

  localparam logic [WIDTH_W-1:0] GRID_WIDTH_RST   = 7'd64;
  localparam logic [MASK_W-1:0]  BIRTH_MASK_RST   = 9'd8;
  localparam logic [MASK_W-1:0]  SURVIVE_MASK_RST = 9'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_BIRTH_MASK   = 2'd1,
    REG_SURVIVE_MASK = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] grid_width;
    logic [MASK_W-1:0]  birth_mask;
    logic [MASK_W-1:0]  survive_mask;
  } rule_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             last;
  } res_entry_t;

  // Which results the staged row asks the output queue to take.
  typedef struct packed {
    logic valid;
    logic want_a;
    logic want_b;
  } push_req_t;

endpackage

// ===== design/llrs_if.sv =====
// Stream interfaces for the row step block: input rows and result rows.
// Depends on llrs_pkg for the row width.
`timescale 1ns / 1ps
interface llrs_row_if import llrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             first_row;
  logic             last_row;

  modport source (output valid, row_cells, first_row, last_row, input ready);
  modport sink (input valid, row_cells, first_row, last_row, output ready);
endinterface

interface llrs_res_if import llrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row;
  logic             last;

  modport source (output valid, next_row, last, input ready);
  modport sink (input valid, next_row, last, output ready);
endinterface

// ===== design/llrs_lane.sv =====
// One cell of the automaton: counts the eight neighbours and applies the rule.
// Depends on llrs_pkg.
`timescale 1ns / 1ps
module llrs_lane import llrs_pkg::*; (
  input  logic [2:0]        up,
  input  logic [2:0]        mid,
  input  logic [2:0]        down,
  input  logic              in_use,
  input  logic [MASK_W-1:0] birth_mask,
  input  logic [MASK_W-1:0] survive_mask,
  output logic              cell_next
);
  logic [CNT_W-1:0] count;
  logic             rule_bit;

  assign count = CNT_W'(up[0]) + CNT_W'(up[1]) + CNT_W'(up[2])
               + CNT_W'(mid[0]) + CNT_W'(mid[2])
               + CNT_W'(down[0]) + CNT_W'(down[1]) + CNT_W'(down[2]);

  // Count never exceeds eight, so it always lands inside the mask.
  assign rule_bit  = mid[1] ? survive_mask[count] : birth_mask[count];
  assign cell_next = rule_bit & in_use;
endmodule

// ===== design/llrs_row_eval.sv =====
// A row of lanes that computes the next generation of the middle of three rows.
// Depends on llrs_pkg and llrs_lane.
`timescale 1ns / 1ps
module llrs_row_eval import llrs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  rule_cfg_t            cfg,
  input  logic [MAX_WIDTH-1:0] up,
  input  logic [MAX_WIDTH-1:0] mid,
  input  logic [MAX_WIDTH-1:0] down,
  output logic [MAX_WIDTH-1:0] next_row
);
  logic [MAX_WIDTH-1:0] in_use;
  logic [MAX_WIDTH+1:0] u_pad, m_pad, d_pad;

  // Cells at or past the grid width read as dead; padding gives dead borders.
  assign u_pad = {1'b0, up & in_use, 1'b0};
  assign m_pad = {1'b0, mid & in_use, 1'b0};
  assign d_pad = {1'b0, down & in_use, 1'b0};

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_lane
    assign in_use[i] = WIDTH_W'(i) < cfg.grid_width;

    llrs_lane u_lane (
      .up           (u_pad[i+2:i]),
      .mid          (m_pad[i+2:i]),
      .down         (d_pad[i+2:i]),
      .in_use       (in_use[i]),
      .birth_mask   (cfg.birth_mask),
      .survive_mask (cfg.survive_mask),
      .cell_next    (next_row[i])
    );
  end
endmodule

// ===== design/llrs_out_queue.sv =====
// Three-entry result queue that takes up to two results a cycle while they fit
// and drives the result channel. Depends on llrs_pkg and llrs_if.
`timescale 1ns / 1ps
module llrs_out_queue import llrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_req_t   req,
  input  res_entry_t  res_a,
  input  res_entry_t  res_b,
  output logic        take,
  llrs_res_if.source  out_res
);
  res_entry_t q [QDEPTH];
  res_entry_t q_next [QDEPTH];
  logic [1:0] cnt, cnt_next, base, need, slot_b;
  logic       pop, room;

  assign pop    = (cnt != 2'd0) && out_res.ready;
  assign base   = cnt - 2'(pop);
  assign need   = 2'(req.want_a) + 2'(req.want_b);
  assign room   = (3'(base) + 3'(need)) <= 3'(QDEPTH);
  assign take   = req.valid && room;
  assign slot_b = base + 2'(req.want_a);

  always_comb begin
    q_next = q;
    if (pop) begin
      for (int k = 0; k < QDEPTH - 1; k++) begin
        q_next[k] = q[k+1];
      end
    end
    if (take && req.want_a) begin
      q_next[base] = res_a;
    end
    if (take && req.want_b) begin
      q_next[slot_b] = res_b;
    end
    cnt_next = take ? base + need : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign out_res.valid    = cnt != 2'd0;
  assign out_res.next_row = q[0].next_row;
  assign out_res.last     = q[0].last;
endmodule

// ===== design/life_like_automaton_row_step.sv =====
// Top level of the life-like automaton row step: row history, staging
// register, two lane rows and the result queue. Depends on llrs_pkg, llrs_if,
// llrs_row_eval and llrs_out_queue.
//
// Usage: grid rows enter top to bottom on in_row, one transaction per row,
// bit i of row_cells being cell i. first_row marks the top row and last_row
// the bottom row of a grid. Each row after the top one yields one result
// transaction on out_res with the next generation of the row above it; the
// bottom row yields a second one with its own next generation and last set.
// A result passes through the staging register and then the result queue before
// it is valid on out_res; its transaction completes at an edge with ready high.
// Throughput: one row per cycle while the staged results fit in the queue; two
// row evaluators of MAX_WIDTH lanes each compute both possible results at once,
// so the single output port, one result per cycle, paces a two-result row.
// Rules and width come from the plain write port (cfg_wr_en, cfg_index,
// cfg_data); the user writes them while the block is idle (not enforced).
// Reset (rst, synchronous) clears the row history, the staging register and
// the result queue, and loads B3/S23 with a width of 64 cells.
// When the receiver stalls, results wait in a three-entry queue and in_row
// keeps taking rows until the staged row's results no longer fit in it.
`timescale 1ns / 1ps
module life_like_automaton_row_step import llrs_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  llrs_row_if.sink              in_row,
  llrs_res_if.source            out_res
);
  // Configuration registers.
  rule_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width   <= GRID_WIDTH_RST;
      cfg.birth_mask   <= BIRTH_MASK_RST;
      cfg.survive_mask <= SURVIVE_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_WIDTH:   cfg.grid_width   <= cfg_data[WIDTH_W-1:0];
        REG_BIRTH_MASK:   cfg.birth_mask   <= cfg_data[MASK_W-1:0];
        REG_SURVIVE_MASK: cfg.survive_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Row history: the row above the pending one and the pending row itself.
  logic [MAX_WIDTH-1:0] above_row, middle_row;
  logic                 middle_valid;
  logic                 accept, produce_a, take;
  logic [MAX_WIDTH-1:0] row_in;

  assign row_in    = in_row.row_cells[MAX_WIDTH-1:0];
  assign accept    = in_row.valid && in_row.ready;
  // A row closes the pending one unless it opens a new grid.
  assign produce_a = middle_valid && !in_row.first_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      above_row    <= '0;
      middle_row   <= '0;
      middle_valid <= 1'b0;
    end else if (accept) begin
      if (in_row.last_row) begin
        above_row    <= '0;
        middle_row   <= '0;
        middle_valid <= 1'b0;
      end else begin
        above_row    <= produce_a ? middle_row : '0;
        middle_row   <= row_in;
        middle_valid <= 1'b1;
      end
    end
  end

  // Staging register: the three rows for the closing result and the flags
  // saying which results this row produces.
  logic                 s_valid, s_a, s_b;
  logic [MAX_WIDTH-1:0] s_up, s_mid, s_row;

  assign in_row.ready = !s_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (take) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_up  <= above_row;
      s_mid <= middle_row;
      s_row <= row_in;
      s_a   <= produce_a;
      s_b   <= in_row.last_row;
    end
  end

  // Result A is the pending row's next generation; result B is the bottom
  // row's own, with a dead row below and the pending row above if it existed.
  logic [MAX_WIDTH-1:0] next_a, next_b, above_b;

  assign above_b = s_a ? s_mid : '0;

  llrs_row_eval #(.MAX_WIDTH(MAX_WIDTH)) u_eval_a (
    .cfg      (cfg),
    .up       (s_up),
    .mid      (s_mid),
    .down     (s_row),
    .next_row (next_a)
  );

  llrs_row_eval #(.MAX_WIDTH(MAX_WIDTH)) u_eval_b (
    .cfg      (cfg),
    .up       (above_b),
    .mid      (s_row),
    .down     ('0),
    .next_row (next_b)
  );

  // The queue merges the two lane rows into one ordered result stream.
  push_req_t  req;
  res_entry_t res_a, res_b;

  assign req.valid      = s_valid;
  assign req.want_a     = s_a;
  assign req.want_b     = s_b;
  assign res_a.next_row = ROW_W'(next_a);
  assign res_a.last     = 1'b0;
  assign res_b.next_row = ROW_W'(next_b);
  assign res_b.last     = 1'b1;

  llrs_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res_a   (res_a),
    .res_b   (res_b),
    .take    (take),
    .out_res (out_res)
  );
endmodule

// ===== design/llrs_checker.sv =====
// Port-level checker for the row step block, bound to its top level.
// Depends on assert_macros.svh and llrs_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module llrs_checker import llrs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_next_row,
  input logic             out_last
);
  // Reset empties the result queue.
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)
  // Reset empties the staging register, so a row can be taken at once.
  `ASSERT_ALWAYS(a_rst_ready, clk, rst |=> in_ready)
  // A stalled result is neither dropped nor changed.
  `ASSERT_SYNC(a_stall_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(out_next_row) && $stable(out_last))
endmodule

bind life_like_automaton_row_step llrs_checker u_llrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_row.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_next_row (out_res.next_row),
  .out_last     (out_res.last)
);
